/* sv/b64d_pkg.sv */
`timescale 1ns / 1ps

package b64d_pkg;

  localparam int MaxStringChars = 256;
  localparam int ByteLimitRaw   = MaxStringChars / 4 * 3;
  localparam logic [7:0] ByteLimit = (ByteLimitRaw > 255) ? 8'd255 : 8'(ByteLimitRaw);

  localparam int FifoDepth   = 8;
  localparam int FifoPtrW    = $clog2(FifoDepth);
  localparam int FifoCntW    = $clog2(FifoDepth + 1);
  localparam int MaxResults  = 4;

  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharUnder = 8'h5F;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic       bad_input;
    logic [7:0] byte_count;
    logic       last_result;
  } out_t;

  typedef struct packed {
    logic [2:0]                 n;
    out_t [MaxResults-1:0]      item;
  } push_t;

endpackage

/* sv/b64d_core.sv */
`timescale 1ns / 1ps

module b64d_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  b64d_pkg::in_t  in_data_i,
  output b64d_pkg::push_t push_o
);

  typedef enum logic [1:0] {
    PhDecoding = 2'd0,
    PhStopped  = 2'd1,
    PhError    = 2'd2
  } phase_e;

  typedef struct packed {
    logic [1:0]  pos;
    logic [17:0] held;
    logic        third_pad;
    phase_e      phase;
    logic        at_start;
    logic        first_dash;
    logic [7:0]  count;
  } state_t;

  typedef struct packed {
    state_t          st;
    logic [1:0]      n;
    logic [2:0][7:0] b;
  } feed_t;

  localparam logic [6:0] NoValue = 7'd64;

  localparam state_t StateReset = '{
    pos: 2'd0, held: 18'd0, third_pad: 1'b0, phase: PhDecoding,
    at_start: 1'b1, first_dash: 1'b0, count: 8'd0
  };

  function automatic logic [6:0] sextet_of(logic [7:0] c);
    logic [6:0] v;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == b64d_pkg::CharDash) begin
      v = 7'd62;
    end else if (c == b64d_pkg::CharUnder) begin
      v = 7'd63;
    end else begin
      v = NoValue;
    end
    return v;
  endfunction

  function automatic feed_t feed(state_t s, logic [7:0] c);
    feed_t           r;
    logic            pad;
    logic [6:0]      v;
    logic [2:0][7:0] cand;
    logic [1:0]      ncand;
    r      = '0;
    r.st   = s;
    pad    = (c == b64d_pkg::CharPad);
    v      = pad ? 7'd0 : sextet_of(c);
    cand   = '0;
    ncand  = '0;
    if (s.phase == PhDecoding) begin
      if (!pad && v == NoValue) begin
        r.st.phase = PhError;
      end else begin
        unique case (s.pos)
          2'd0: begin
            if (pad) begin
              r.st.phase = PhError;
            end else begin
              r.st.held = {v[5:0], 12'd0};
              r.st.pos  = 2'd1;
            end
          end
          2'd1: begin
            if (pad) begin
              r.st.phase = PhError;
            end else begin
              r.st.held[11:6] = v[5:0];
              r.st.pos        = 2'd2;
            end
          end
          2'd2: begin
            if (pad) begin
              r.st.third_pad = 1'b1;
            end else begin
              r.st.held[5:0] = v[5:0];
            end
            r.st.pos = 2'd3;
          end
          default: begin
            cand[0] = {s.held[17:12], s.held[11:10]};
            cand[1] = {s.held[9:6], s.held[5:2]};
            cand[2] = {s.held[1:0], v[5:0]};
            ncand   = s.third_pad ? 2'd1 : (pad ? 2'd2 : 2'd3);
            for (int i = 0; i < 3; i++) begin
              if (2'(i) < ncand && r.st.phase != PhError) begin
                if (r.st.count >= b64d_pkg::ByteLimit) begin
                  r.st.phase = PhError;
                end else begin
                  r.st.count = r.st.count + 8'd1;
                  r.b[r.n]   = cand[i];
                  r.n        = r.n + 2'd1;
                end
              end
            end
            r.st.pos       = 2'd0;
            r.st.held      = '0;
            r.st.third_pad = 1'b0;
            if (pad && r.st.phase == PhDecoding) begin
              r.st.phase = PhStopped;
            end
          end
        endcase
      end
    end
    return r;
  endfunction

  state_t state_q, state_d;
  feed_t  fr;
  state_t src;
  logic   main_feed;
  logic   bad;
  logic [2:0] n;
  b64d_pkg::out_t [b64d_pkg::MaxResults-1:0] items;

  always_comb begin
    state_d   = state_q;
    src       = state_q;
    main_feed = 1'b0;
    fr        = '0;
    bad       = 1'b0;
    items     = '0;
    n         = 3'd0;
    if (state_q.at_start) begin
      state_d.at_start = 1'b0;
      if (in_data_i.character == b64d_pkg::CharDash) begin
        state_d.first_dash = 1'b1;
      end else begin
        main_feed = 1'b1;
        src       = state_d;
      end
    end else if (state_q.first_dash) begin
      state_d.first_dash = 1'b0;
      if (in_data_i.character != b64d_pkg::CharSpace) begin
        main_feed = 1'b1;
        src       = feed(state_d, b64d_pkg::CharDash).st;
      end
    end else begin
      main_feed = 1'b1;
    end
    if (main_feed) begin
      fr      = feed(src, in_data_i.character);
      state_d = fr.st;
      n       = {1'b0, fr.n};
    end
    for (int i = 0; i < 3; i++) begin
      items[i].kind      = b64d_pkg::KindData;
      items[i].data_byte = fr.b[i];
    end
    if (in_data_i.last_char) begin
      if (state_d.first_dash) begin
        state_d.first_dash = 1'b0;
        state_d = feed(state_d, b64d_pkg::CharDash).st;
      end
      if (state_d.phase == PhDecoding && state_d.pos != 2'd0) begin
        state_d.phase = PhError;
      end
      bad = (state_d.phase == PhError);
      items[n[1:0]].kind        = b64d_pkg::KindStatus;
      items[n[1:0]].data_byte   = 8'd0;
      items[n[1:0]].bad_input   = bad;
      items[n[1:0]].byte_count  = bad ? 8'd0 : state_d.count;
      items[n[1:0]].last_result = 1'b0;
      n       = n + 3'd1;
      state_d = StateReset;
    end
    if (n != 3'd0) begin
      items[2'(n - 3'd1)].last_result = 1'b1;
    end
    push_o.item = items;
    push_o.n    = fire_i ? n : 3'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (fire_i) begin
      state_q <= state_d;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.n <= 3'(b64d_pkg::MaxResults))
    else $error("more results than slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.n != 3'd0) |-> push_o.item[2'(push_o.n - 3'd1)].last_result)
    else $error("final result not flagged");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && in_data_i.last_char) |=> (state_q.at_start && state_q.count == 8'd0))
    else $error("state not reset after end of string");
`endif

endmodule

/* sv/b64d_fifo.sv */
`timescale 1ns / 1ps

module b64d_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  b64d_pkg::push_t push_i,
  output logic            room_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output b64d_pkg::out_t  out_data_o
);

  localparam int PtrW = b64d_pkg::FifoPtrW;
  localparam int CntW = b64d_pkg::FifoCntW;

  b64d_pkg::out_t mem_q [b64d_pkg::FifoDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q, count_d;
  logic            pop;

  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (count_q <= CntW'(b64d_pkg::FifoDepth - b64d_pkg::MaxResults));
  assign count_d     = count_q + CntW'(push_i.n) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < b64d_pkg::MaxResults; i++) begin
      if (3'(i) < push_i.n) begin
        mem_q[PtrW'(wr_ptr_q + PtrW'(i))] <= push_i.item[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= PtrW'(wr_ptr_q + PtrW'(push_i.n));
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      count_q <= count_d;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(b64d_pkg::FifoDepth))
    else $error("result queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n != 3'd0) |-> room_o)
    else $error("push without room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.n == 3'd0 && pop) |=> (count_q == $past(count_q) - CntW'(1)))
    else $error("queue count lost a transfer");
`endif

endmodule

/* sv/base64url_decoder_unit.sv */
`timescale 1ns / 1ps

// base64url decoder, one character per input transfer, last_char on the final one.
// input channel: in_valid_i / in_stall_o / in_data_i (character, last_char).
// output channel: out_valid_o / out_stall_i / out_data_o, one result per transfer:
//   data bytes (kind 0) and, after the last character, one status item (kind 1)
//   with bad_input and byte_count; last_result marks the final result of a character.
// a character is taken into an input register, decoded there against the string state,
// and its zero to four results are written to an 8-entry result queue.
// the first result is offered from the queue once the character has been decoded
// and written there, which waits while the queue lacks room.
// throughput: one character per cycle while the queue has room for four results;
// results drain at one per cycle, so a stalled receiver fills the queue and then
// raises in_stall_o.
// on error the data bytes already sent are to be dropped by the receiver.
// reset clears the string state, the input register's valid flag and the queue; the first
// character after reset starts a new string.

module base64url_decoder_unit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  b64d_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output b64d_pkg::out_t out_data_o
);

  logic            s1_valid_q;
  b64d_pkg::in_t   s1_data_q;
  logic            room;
  logic            fire;
  b64d_pkg::push_t push;

  assign fire       = s1_valid_q && room;
  assign in_stall_o = s1_valid_q && !room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
  end

  b64d_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .in_data_i (s1_data_q),
    .push_o    (push)
  );

  b64d_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
